>>> sv/qvr_pkg.sv
// Shared types and constants for the quaternion vector rotation pipeline.
// Used by every module of the block; depends on nothing else.
package qvr_pkg;

  localparam int DataW     = 32;            // width of one input or result component
  localparam int QuatN     = 4;             // quaternion components, w first
  localparam int MagW      = 32;            // magnitude of a 32-bit signed value
  localparam int SMagW     = 31;            // magnitude after pre-scaling, at most 2^30
  localparam int SqW       = 2 * SMagW;     // square of a scaled magnitude
  localparam int SumW      = SqW + 1;       // sum of four squares
  localparam int RootW     = 32;            // integer square root of the sum
  localparam int UnitShift = 30;            // fraction bits of the unit quaternion
  localparam int InW       = 7 * DataW;     // packed input item
  localparam int OutW      = 3 * DataW;     // packed result vector
  localparam int UserW     = 2;             // result flags

  // Component positions inside a quaternion array.
  localparam int QW = 0;
  localparam int QX = 1;
  localparam int QY = 2;
  localparam int QZ = 3;

  // Flag positions inside the result tuser.
  localparam int UserZero = 0;
  localparam int UserOvf  = 1;

  typedef logic [QuatN-1:0][SMagW-1:0] mag4_t;

  typedef struct packed {
    logic signed [DataW-1:0] x;
    logic signed [DataW-1:0] y;
    logic signed [DataW-1:0] z;
  } vec_t;

  // Data that rides along with an item through the arithmetic stages.
  typedef struct packed {
    vec_t             vec;
    logic [QuatN-1:0] neg;
    logic             zero;
  } side_t;

endpackage

>>> sv/quaternion_vector_rotate.sv
// Top level of the quaternion vector rotation pipeline.
// Instantiates qvr_norm, qvr_sqrt, qvr_div and qvr_rot; uses qvr_pkg.
//
// Usage:
//   The slave stream takes one item per handshake: a vector and a quaternion,
//   all signed Q16.16 words. The quaternion need not have unit length.
//   The master stream returns the rotated vector, saturated to 32 bits, with
//   tuser flags for a zero quaternion (vector forced to zero) and overflow.
//   An item passes through 6 stages of magnitude, scaling and squares,
//   32 stages of square root (one root bit per stage), 32 stages of division
//   (setup plus one quotient bit per stage) and 6 stages of products and
//   rounding. Throughput is one item per cycle unless the receiver stalls.
//   Every stage moves on a common enable that is high when the output
//   register is empty or being taken, so s_axis_tready follows that enable.
//   When the receiver stalls with a result waiting, the whole pipe holds and
//   nothing is dropped or repeated. Reset clears all valid bits; the pipe is
//   ready as soon as reset is released.
module quaternion_vector_rotate import qvr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // vec_x, vec_y, vec_z, quat_x, quat_y, quat_z, quat_w
  input  logic [InW-1:0]   s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // rot_x, rot_y, rot_z
  output logic [OutW-1:0]  m_axis_tdata,
  // zero_quat, overflow
  output logic [UserW-1:0] m_axis_tuser
);

  logic                        en;
  logic [QuatN-1:0][DataW-1:0] quat;
  vec_t                        vec;

  logic                        n_vld, s_vld, d_vld, r_vld;
  logic [SumW-1:0]             n_sum;
  mag4_t                       n_mag, s_mag, d_unit;
  side_t                       n_side, s_side, d_side;
  logic [RootW-1:0]            s_root;
  logic                        r_zero, r_ovf;

  assign en = !r_vld || m_axis_tready;

  assign vec.x    = s_axis_tdata[0*DataW +: DataW];
  assign vec.y    = s_axis_tdata[1*DataW +: DataW];
  assign vec.z    = s_axis_tdata[2*DataW +: DataW];
  assign quat[QX] = s_axis_tdata[3*DataW +: DataW];
  assign quat[QY] = s_axis_tdata[4*DataW +: DataW];
  assign quat[QZ] = s_axis_tdata[5*DataW +: DataW];
  assign quat[QW] = s_axis_tdata[6*DataW +: DataW];

  qvr_norm u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s_axis_tvalid),
    .quat_i (quat),
    .vec_i  (vec),
    .vld_o  (n_vld),
    .sum_o  (n_sum),
    .mag_o  (n_mag),
    .side_o (n_side)
  );

  qvr_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (n_vld),
    .sum_i  (n_sum),
    .mag_i  (n_mag),
    .side_i (n_side),
    .vld_o  (s_vld),
    .root_o (s_root),
    .mag_o  (s_mag),
    .side_o (s_side)
  );

  qvr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s_vld),
    .root_i (s_root),
    .mag_i  (s_mag),
    .side_i (s_side),
    .vld_o  (d_vld),
    .unit_o (d_unit),
    .side_o (d_side)
  );

  qvr_rot u_rot (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (d_vld),
    .unit_i (d_unit),
    .side_i (d_side),
    .vld_o  (r_vld),
    .rot_o  (m_axis_tdata),
    .zero_o (r_zero),
    .ovf_o  (r_ovf)
  );

  assign s_axis_tready          = en;
  assign m_axis_tvalid          = r_vld;
  assign m_axis_tuser[UserZero] = r_zero;
  assign m_axis_tuser[UserOvf]  = r_ovf;

`ifndef SYNTHESIS
  // A zero quaternion always yields a zero vector without overflow.
  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[UserZero] |->
      m_axis_tdata == '0 && !m_axis_tuser[UserOvf])
    else $error("zero quaternion result is not a clean zero vector");

  // Overflow is only reported when some component sits at a saturation limit.
  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[UserOvf] |->
      m_axis_tdata[31:0]  == 32'h7fff_ffff || m_axis_tdata[31:0]  == 32'h8000_0000 ||
      m_axis_tdata[63:32] == 32'h7fff_ffff || m_axis_tdata[63:32] == 32'h8000_0000 ||
      m_axis_tdata[95:64] == 32'h7fff_ffff || m_axis_tdata[95:64] == 32'h8000_0000)
    else $error("overflow flagged without a saturated component");

  // A result left waiting must freeze the pipe, so no new item may enter.
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while the output is stalled");
`endif

endmodule

>>> sv/qvr_norm.sv
// Front end: magnitudes, pre-scaling and sum of squares of the quaternion.
// Six register stages; uses qvr_pkg.
module qvr_norm import qvr_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  logic [QuatN-1:0][DataW-1:0] quat_i,
  input  vec_t                        vec_i,
  output logic                        vld_o,
  output logic [SumW-1:0]             sum_o,
  output mag4_t                       mag_o,
  output side_t                       side_o
);

  logic [5:0] vld_q;

  // Stage 1: input register.
  logic [QuatN-1:0][DataW-1:0] s1_quat_q;
  vec_t                        s1_vec_q;
  // Stage 2: magnitudes and maximum.
  logic [QuatN-1:0][MagW-1:0]  s2_mag_q, s2_mag_d;
  logic [MagW-1:0]             s2_m_q, s2_m_d;
  logic [QuatN-1:0]            s2_neg_q, s2_neg_d;
  vec_t                        s2_vec_q;
  // Stage 3: shift amount.
  logic [QuatN-1:0][MagW-1:0]  s3_mag_q;
  logic [4:0]                  s3_k_q, s3_k_d;
  logic                        s3_big_q, s3_big_d;
  side_t                       s3_side_q, s3_side_d;
  // Stage 4: scaled magnitudes.
  mag4_t                       s4_mag_q, s4_mag_d;
  side_t                       s4_side_q;
  // Stage 5: squares.
  logic [QuatN-1:0][SqW-1:0]   s5_sq_q, s5_sq_d;
  mag4_t                       s5_mag_q;
  side_t                       s5_side_q;
  // Stage 6: sum.
  logic [SumW-1:0]             s6_sum_q, s6_sum_d;
  mag4_t                       s6_mag_q;
  side_t                       s6_side_q;

  always_comb begin
    logic [MagW-1:0] m01, m23;
    for (int i = 0; i < QuatN; i++) begin
      s2_neg_d[i] = s1_quat_q[i][DataW-1];
      s2_mag_d[i] = s1_quat_q[i][DataW-1] ? -s1_quat_q[i] : s1_quat_q[i];
    end
    m01    = (s2_mag_d[0] > s2_mag_d[1]) ? s2_mag_d[0] : s2_mag_d[1];
    m23    = (s2_mag_d[2] > s2_mag_d[3]) ? s2_mag_d[2] : s2_mag_d[3];
    s2_m_d = (m01 > m23) ? m01 : m23;
  end

  // The largest magnitude is brought as close to 2^30 as a left shift allows,
  // or halved once when it is above 2^30.
  always_comb begin
    logic [4:0] msb;
    logic       pow2;
    msb = '0;
    for (int b = 0; b < SMagW; b++) begin
      if (s2_m_q[b]) msb = 5'(b);
    end
    pow2     = (s2_m_q & (s2_m_q - 1'b1)) == '0;
    s3_big_d = s2_m_q > (MagW'(1) << UnitShift);
    s3_k_d   = pow2 ? 5'(UnitShift - int'(msb)) : 5'(UnitShift - 1 - int'(msb));
    s3_side_d.vec  = s2_vec_q;
    s3_side_d.neg  = s2_neg_q;
    s3_side_d.zero = s2_m_q == '0;
  end

  always_comb begin
    logic [MagW-1:0] shl;
    for (int i = 0; i < QuatN; i++) begin
      shl         = s3_mag_q[i] << s3_k_q;
      s4_mag_d[i] = s3_big_q ? SMagW'(s3_mag_q[i] >> 1) : shl[SMagW-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < QuatN; i++) begin
      s5_sq_d[i] = SqW'(s4_mag_q[i]) * SqW'(s4_mag_q[i]);
    end
    s6_sum_d = SumW'(s5_sq_q[0]) + SumW'(s5_sq_q[1]) + SumW'(s5_sq_q[2]) + SumW'(s5_sq_q[3]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_quat_q <= quat_i;
      s1_vec_q  <= vec_i;
      s2_mag_q  <= s2_mag_d;
      s2_m_q    <= s2_m_d;
      s2_neg_q  <= s2_neg_d;
      s2_vec_q  <= s1_vec_q;
      s3_mag_q  <= s2_mag_q;
      s3_k_q    <= s3_k_d;
      s3_big_q  <= s3_big_d;
      s3_side_q <= s3_side_d;
      s4_mag_q  <= s4_mag_d;
      s4_side_q <= s3_side_q;
      s5_sq_q   <= s5_sq_d;
      s5_mag_q  <= s4_mag_q;
      s5_side_q <= s4_side_q;
      s6_sum_q  <= s6_sum_d;
      s6_mag_q  <= s5_mag_q;
      s6_side_q <= s5_side_q;
    end
  end

  assign vld_o  = vld_q[5];
  assign sum_o  = s6_sum_q;
  assign mag_o  = s6_mag_q;
  assign side_o = s6_side_q;

endmodule

>>> sv/qvr_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Carries the scaled magnitudes and side data alongside; uses qvr_pkg.
module qvr_sqrt import qvr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [SumW-1:0]  sum_i,
  input  mag4_t            mag_i,
  input  side_t            side_i,
  output logic             vld_o,
  output logic [RootW-1:0] root_o,
  output mag4_t            mag_o,
  output side_t            side_o
);

  localparam int Steps = RootW;
  localparam int RadW  = 2 * RootW;
  localparam int RemW  = RootW + 2;

  logic [Steps-1:0] vld_q;
  logic [RadW-1:0]  rad_q  [Steps];
  logic [RadW-1:0]  rad_d  [Steps];
  logic [RemW-1:0]  rem_q  [Steps];
  logic [RemW-1:0]  rem_d  [Steps];
  logic [RootW-1:0] root_q [Steps];
  logic [RootW-1:0] root_d [Steps];
  mag4_t            mag_q  [Steps];
  side_t            side_q [Steps];

  // Each stage brings down the next two radicand bits and tries root*4+1.
  always_comb begin
    logic [RadW-1:0]  rad_in;
    logic [RemW-1:0]  rem_in;
    logic [RootW-1:0] root_in;
    logic [RemW+1:0]  cand, trial;
    for (int j = 0; j < Steps; j++) begin
      if (j == 0) begin
        rad_in  = RadW'(sum_i);
        rem_in  = '0;
        root_in = '0;
      end else begin
        rad_in  = rad_q[j-1];
        rem_in  = rem_q[j-1];
        root_in = root_q[j-1];
      end
      cand  = {rem_in, rad_in[RadW-1 -: 2]};
      trial = {2'b00, root_in, 2'b01};
      if (cand >= trial) begin
        rem_d[j]  = RemW'(cand - trial);
        root_d[j] = {root_in[RootW-2:0], 1'b1};
      end else begin
        rem_d[j]  = cand[RemW-1:0];
        root_d[j] = {root_in[RootW-2:0], 1'b0};
      end
      rad_d[j] = rad_in << 2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Steps-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < Steps; j++) begin
        rad_q[j]  <= rad_d[j];
        rem_q[j]  <= rem_d[j];
        root_q[j] <= root_d[j];
        if (j == 0) begin
          mag_q[j]  <= mag_i;
          side_q[j] <= side_i;
        end else begin
          mag_q[j]  <= mag_q[j-1];
          side_q[j] <= side_q[j-1];
        end
      end
    end
  end

  assign vld_o  = vld_q[Steps-1];
  assign root_o = root_q[Steps-1];
  assign mag_o  = mag_q[Steps-1];
  assign side_o = side_q[Steps-1];

endmodule

>>> sv/qvr_div.sv
// Four-lane pipelined restoring divider: unit component = round(mag * 2^30 / n).
// One setup stage, then one quotient bit per stage; uses qvr_pkg.
module qvr_div import qvr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [RootW-1:0] root_i,
  input  mag4_t            mag_i,
  input  side_t            side_i,
  output logic             vld_o,
  output mag4_t            unit_o,
  output side_t            side_o
);

  localparam int QW_   = SMagW;               // quotient bits, at most 2^30
  localparam int DivW  = SMagW + UnitShift;   // dividend width
  localparam int Steps = QW_ + 1;
  localparam int RemW  = RootW;

  typedef logic [QuatN-1:0][RemW-1:0] rem4_t;

  logic [Steps-1:0] vld_q;
  rem4_t            rem_q  [Steps];
  rem4_t            rem_d  [Steps];
  mag4_t            dlo_q  [Steps];
  mag4_t            dlo_d  [Steps];
  mag4_t            quo_q  [Steps];
  mag4_t            quo_d  [Steps];
  logic [RootW-1:0] den_q  [Steps];
  side_t            side_q [Steps];

  always_comb begin
    logic [DivW-1:0] dvd;
    logic [RemW:0]   cand;
    for (int j = 0; j < Steps; j++) begin
      for (int i = 0; i < QuatN; i++) begin
        if (j == 0) begin
          // Dividend with the half-divisor rounding term; its top bits are
          // already below the divisor.
          dvd         = {mag_i[i], UnitShift'(0)} + DivW'(root_i >> 1);
          rem_d[j][i] = RemW'(dvd[DivW-1:QW_]);
          dlo_d[j][i] = dvd[QW_-1:0];
          quo_d[j][i] = '0;
        end else begin
          cand = {rem_q[j-1][i], dlo_q[j-1][i][QW_-1]};
          if (cand >= {1'b0, den_q[j-1]}) begin
            rem_d[j][i] = RemW'(cand - {1'b0, den_q[j-1]});
            quo_d[j][i] = {quo_q[j-1][i][QW_-2:0], 1'b1};
          end else begin
            rem_d[j][i] = cand[RemW-1:0];
            quo_d[j][i] = {quo_q[j-1][i][QW_-2:0], 1'b0};
          end
          dlo_d[j][i] = dlo_q[j-1][i] << 1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Steps-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < Steps; j++) begin
        rem_q[j] <= rem_d[j];
        dlo_q[j] <= dlo_d[j];
        quo_q[j] <= quo_d[j];
        if (j == 0) begin
          den_q[j]  <= root_i;
          side_q[j] <= side_i;
        end else begin
          den_q[j]  <= den_q[j-1];
          side_q[j] <= side_q[j-1];
        end
      end
    end
  end

  assign vld_o  = vld_q[Steps-1];
  assign unit_o = quo_q[Steps-1];
  assign side_o = side_q[Steps-1];

endmodule

>>> sv/qvr_rot.sv
// Back end: the two Hamilton products, rounding, saturation and result flags.
// Six register stages, the last one is the output register; uses qvr_pkg.
module qvr_rot import qvr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  mag4_t            unit_i,
  input  side_t            side_i,
  output logic             vld_o,
  output logic [OutW-1:0]  rot_o,
  output logic             zero_o,
  output logic             ovf_o
);

  localparam int ProdW = 2 * DataW;
  localparam int SumAW = ProdW + 2;
  localparam int PW    = DataW + 3;
  localparam int ProdB = PW + DataW;
  localparam int SumBW = ProdB + 2;
  localparam int RndW  = SumBW - UnitShift;

  localparam logic signed [SumAW-1:0] BiasA = SumAW'(1) <<< (UnitShift - 1);
  localparam logic signed [SumBW-1:0] BiasB = SumBW'(1) <<< (UnitShift - 1);
  localparam logic signed [RndW-1:0]  SatMax = RndW'(32'sh7fff_ffff);
  localparam logic signed [RndW-1:0]  SatMin = ~SatMax;

  logic [5:0] vld_q;

  // R1: signed unit quaternion.
  logic signed [DataW-1:0] u1_q [QuatN];
  logic signed [DataW-1:0] u1_d [QuatN];
  vec_t                    r1_vec_q;
  logic                    r1_zero_q;
  // R2: products of u and the vector.
  logic signed [ProdW-1:0] a_q [12];
  logic signed [ProdW-1:0] a_d [12];
  logic signed [DataW-1:0] u2_q [QuatN];
  logic                    r2_zero_q;
  // R3: first product, back at vector scale.
  logic signed [PW-1:0]    p_q [QuatN];
  logic signed [PW-1:0]    p_d [QuatN];
  logic signed [DataW-1:0] u3_q [QuatN];
  logic                    r3_zero_q;
  // R4: products of p and the conjugate.
  logic signed [ProdB-1:0] b_q [12];
  logic signed [ProdB-1:0] b_d [12];
  logic                    r4_zero_q;
  // R5: exact sums of the rotated vector.
  logic signed [SumBW-1:0] r_q [3];
  logic signed [SumBW-1:0] r_d [3];
  logic                    r5_zero_q;
  // R6: output register.
  logic [OutW-1:0]         rot_q, rot_d;
  logic                    zero_q;
  logic                    ovf_q, ovf_d;

  always_comb begin
    logic signed [DataW-1:0] um;
    for (int i = 0; i < QuatN; i++) begin
      um      = $signed({1'b0, unit_i[i]});
      u1_d[i] = side_i.neg[i] ? -um : um;
    end
  end

  always_comb begin
    logic signed [DataW-1:0] vx, vy, vz;
    vx = $signed(r1_vec_q.x);
    vy = $signed(r1_vec_q.y);
    vz = $signed(r1_vec_q.z);
    a_d[0]  = ProdW'(u1_q[QX]) * ProdW'(vx);
    a_d[1]  = ProdW'(u1_q[QY]) * ProdW'(vy);
    a_d[2]  = ProdW'(u1_q[QZ]) * ProdW'(vz);
    a_d[3]  = ProdW'(u1_q[QW]) * ProdW'(vx);
    a_d[4]  = ProdW'(u1_q[QY]) * ProdW'(vz);
    a_d[5]  = ProdW'(u1_q[QZ]) * ProdW'(vy);
    a_d[6]  = ProdW'(u1_q[QW]) * ProdW'(vy);
    a_d[7]  = ProdW'(u1_q[QX]) * ProdW'(vz);
    a_d[8]  = ProdW'(u1_q[QZ]) * ProdW'(vx);
    a_d[9]  = ProdW'(u1_q[QW]) * ProdW'(vz);
    a_d[10] = ProdW'(u1_q[QX]) * ProdW'(vy);
    a_d[11] = ProdW'(u1_q[QY]) * ProdW'(vx);
  end

  // Rounding adds half an LSB and shifts down, so ties go toward plus infinity.
  always_comb begin
    logic signed [SumAW-1:0] s [QuatN];
    s[QW] = -SumAW'(a_q[0]) - SumAW'(a_q[1]) - SumAW'(a_q[2]);
    s[QX] =  SumAW'(a_q[3]) + SumAW'(a_q[4]) - SumAW'(a_q[5]);
    s[QY] =  SumAW'(a_q[6]) - SumAW'(a_q[7]) + SumAW'(a_q[8]);
    s[QZ] =  SumAW'(a_q[9]) + SumAW'(a_q[10]) - SumAW'(a_q[11]);
    for (int i = 0; i < QuatN; i++) begin
      p_d[i] = PW'((s[i] + BiasA) >>> UnitShift);
    end
  end

  // Second product against the conjugate; its signs are folded into the R5 sums.
  always_comb begin
    b_d[0]  = ProdB'(p_q[QW]) * ProdB'(u3_q[QX]);
    b_d[1]  = ProdB'(p_q[QX]) * ProdB'(u3_q[QW]);
    b_d[2]  = ProdB'(p_q[QY]) * ProdB'(u3_q[QZ]);
    b_d[3]  = ProdB'(p_q[QZ]) * ProdB'(u3_q[QY]);
    b_d[4]  = ProdB'(p_q[QW]) * ProdB'(u3_q[QY]);
    b_d[5]  = ProdB'(p_q[QX]) * ProdB'(u3_q[QZ]);
    b_d[6]  = ProdB'(p_q[QY]) * ProdB'(u3_q[QW]);
    b_d[7]  = ProdB'(p_q[QZ]) * ProdB'(u3_q[QX]);
    b_d[8]  = ProdB'(p_q[QW]) * ProdB'(u3_q[QZ]);
    b_d[9]  = ProdB'(p_q[QX]) * ProdB'(u3_q[QY]);
    b_d[10] = ProdB'(p_q[QY]) * ProdB'(u3_q[QX]);
    b_d[11] = ProdB'(p_q[QZ]) * ProdB'(u3_q[QW]);
  end

  always_comb begin
    r_d[0] = -SumBW'(b_q[0]) + SumBW'(b_q[1]) - SumBW'(b_q[2]) + SumBW'(b_q[3]);
    r_d[1] = -SumBW'(b_q[4]) + SumBW'(b_q[5]) + SumBW'(b_q[6]) - SumBW'(b_q[7]);
    r_d[2] = -SumBW'(b_q[8]) - SumBW'(b_q[9]) + SumBW'(b_q[10]) + SumBW'(b_q[11]);
  end

  always_comb begin
    logic signed [RndW-1:0] x;
    rot_d = '0;
    ovf_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      x = RndW'((r_q[i] + BiasB) >>> UnitShift);
      if (x > SatMax) begin
        x     = SatMax;
        ovf_d = 1'b1;
      end else if (x < SatMin) begin
        x     = SatMin;
        ovf_d = 1'b1;
      end
      rot_d[i*DataW +: DataW] = x[DataW-1:0];
    end
    // A zero quaternion gives a zero vector and no overflow.
    if (r5_zero_q) begin
      rot_d = '0;
      ovf_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u1_q      <= u1_d;
      r1_vec_q  <= side_i.vec;
      r1_zero_q <= side_i.zero;
      a_q       <= a_d;
      u2_q      <= u1_q;
      r2_zero_q <= r1_zero_q;
      p_q       <= p_d;
      u3_q      <= u2_q;
      r3_zero_q <= r2_zero_q;
      b_q       <= b_d;
      r4_zero_q <= r3_zero_q;
      r_q       <= r_d;
      r5_zero_q <= r4_zero_q;
      rot_q     <= rot_d;
      zero_q    <= r5_zero_q;
      ovf_q     <= ovf_d;
    end
  end

  assign vld_o  = vld_q[5];
  assign rot_o  = rot_q;
  assign zero_o = zero_q;
  assign ovf_o  = ovf_q;

endmodule

>>> tb/quaternion_vector_rotate_tb.sv
// Self-checking testbench for quaternion_vector_rotate: rotates random and
// directed vectors by quaternions and compares each result with a local model.
// Depends on qvr_pkg and the quaternion_vector_rotate RTL.
`timescale 1ns / 100ps

module quaternion_vector_rotate_tb import qvr_pkg::*;;

  typedef struct {
    logic [DataW-1:0] rx;
    logic [DataW-1:0] ry;
    logic [DataW-1:0] rz;
    logic             zero;
    logic             ovf;
  } rot_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [InW-1:0]   s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OutW-1:0]  m_axis_tdata;
  logic [UserW-1:0] m_axis_tuser;

  logic [InW-1:0] pending_items[$];
  rot_result_t    rotations_due[$];
  int             n_accepted = 0;
  int             n_errors = 0;
  int             hold_cycles = 0;
  bit             hold_done = 1'b0;

  quaternion_vector_rotate i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s = s - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Rounds a Q*.30 product sum back to the vector scale, ties toward +inf.
  function automatic longint unit_round(longint acc);
    return (acc + (64'sd1 <<< (UnitShift - 1))) >>> UnitShift;
  endfunction

  function automatic void ham_product(input longint a[4], input longint b[4],
                                      output longint o[4]);
    o[QW] = unit_round(a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3]);
    o[QX] = unit_round(a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2]);
    o[QY] = unit_round(a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1]);
    o[QZ] = unit_round(a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0]);
  endfunction

  function automatic rot_result_t rotate_vector(logic [InW-1:0] item);
    rot_result_t     res;
    longint          c[4];
    longint unsigned mag[4];
    longint unsigned m;
    longint unsigned sq;
    longint unsigned nrm;
    longint unsigned q;
    longint          u[4], uc[4], v[4], p[4], r[4];
    longint          x;
    logic [DataW-1:0] outs[3];
    c[QW] = longint'($signed(item[6*DataW +: DataW]));
    c[QX] = longint'($signed(item[3*DataW +: DataW]));
    c[QY] = longint'($signed(item[4*DataW +: DataW]));
    c[QZ] = longint'($signed(item[5*DataW +: DataW]));
    m = 0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = (c[i] < 0) ? -c[i] : c[i];
      if (mag[i] > m) m = mag[i];
    end
    res.ovf = 1'b0;
    if (m == 0) begin
      res.rx = '0; res.ry = '0; res.rz = '0; res.zero = 1'b1;
      return res;
    end
    res.zero = 1'b0;
    // Halve once if above 2^30, else shift up as close to 2^30 as possible.
    if (m > (64'd1 << 30)) begin
      for (int i = 0; i < 4; i++) mag[i] = mag[i] >> 1;
    end else begin
      while ((m << 1) <= (64'd1 << 30)) begin
        m = m << 1;
        for (int i = 0; i < 4; i++) mag[i] = mag[i] << 1;
      end
    end
    sq = 0;
    for (int i = 0; i < 4; i++) sq = sq + mag[i] * mag[i];
    nrm = int_sqrt(sq);
    for (int i = 0; i < 4; i++) begin
      q = ((mag[i] << UnitShift) + (nrm >> 1)) / nrm;
      u[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
      uc[i] = (i == QW) ? u[i] : -u[i];
    end
    v[QW] = 0;
    v[QX] = longint'($signed(item[0 +: DataW]));
    v[QY] = longint'($signed(item[DataW +: DataW]));
    v[QZ] = longint'($signed(item[2*DataW +: DataW]));
    ham_product(u, v, p);
    ham_product(p, uc, r);
    for (int i = 1; i < 4; i++) begin
      x = r[i];
      if (x > 64'sd2147483647) begin
        x = 64'sd2147483647; res.ovf = 1'b1;
      end else if (x < -64'sd2147483648) begin
        x = -64'sd2147483648; res.ovf = 1'b1;
      end
      outs[i-1] = x[DataW-1:0];
    end
    res.rx = outs[0]; res.ry = outs[1]; res.rz = outs[2];
    return res;
  endfunction

  function automatic logic [InW-1:0] pack_item(int vx, int vy, int vz,
                                               int qx, int qy, int qz, int qw);
    return {qw, qz, qy, qx, vz, vy, vx};
  endfunction

  // Idle and stall rates change every 75 accepted items.
  function automatic int phase_now();
    return (n_accepted / 75) % 4;
  endfunction

  // Driver: offers pending items and records the expected rotation on accept.
  always @(posedge clk_i) begin
    int pct;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        rotations_due.push_back(rotate_vector(s_axis_tdata));
        n_accepted <= n_accepted + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        case (phase_now())
          1: pct = 65;
          3: pct = 7;
          default: pct = 0;
        endcase
        if (pending_items.size() > 0 && $urandom_range(99) >= pct) begin
          s_axis_tdata  <= pending_items.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold that backs up the pipe.
  always @(posedge clk_i) begin
    int pct;
    if (rst_ni) begin
      if (!hold_done && n_accepted >= 320) begin
        hold_cycles <= hold_cycles + 1;
        if (hold_cycles >= 300) hold_done <= 1'b1;
        m_axis_tready <= 1'b0;
      end else begin
        case (phase_now())
          2: pct = 65;
          3: pct = 7;
          default: pct = 0;
        endcase
        m_axis_tready <= ($urandom_range(99) >= pct);
      end
    end
  end

  // Monitor: each result against the oldest expected rotation.
  always @(posedge clk_i) begin
    rot_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (rotations_due.size() == 0) begin
        n_errors <= n_errors + 1;
        if (n_errors < 10) $display("Unexpected result item: %h", m_axis_tdata);
      end else begin
        want = rotations_due.pop_front();
        if (m_axis_tdata !== {want.rz, want.ry, want.rx} ||
            m_axis_tuser[UserZero] !== want.zero || m_axis_tuser[UserOvf] !== want.ovf) begin
          n_errors <= n_errors + 1;
          if (n_errors < 10)
            $display("Mismatch: expected x=%h y=%h z=%h zero=%b ovf=%b, got %h user=%b",
                     want.rx, want.ry, want.rz, want.zero, want.ovf, m_axis_tdata,
                     m_axis_tuser);
        end
      end
    end
  end

  initial begin
    int one;
    int big;
    int smallv;
    one = 32'sh0001_0000;
    big = 32'sh7fff_ffff;
    smallv = -32'sh8000_0000;
    // Zero quaternion, identity, and 90 degree turns about each axis.
    pending_items.push_back(pack_item(one, 2*one, 3*one, 0, 0, 0, 0));
    pending_items.push_back(pack_item(big, smallv, 5, 0, 0, 0, 0));
    pending_items.push_back(pack_item(one, 2*one, 3*one, 0, 0, 0, one));
    pending_items.push_back(pack_item(one, 2*one, 3*one, one, 0, 0, one));
    pending_items.push_back(pack_item(one, 2*one, 3*one, 0, one, 0, one));
    pending_items.push_back(pack_item(one, 2*one, 3*one, 0, 0, one, -one));
    // Large vectors, some of whose rotations leave the 32-bit range.
    pending_items.push_back(pack_item(big, big, 0, 0, 0, one, one));
    pending_items.push_back(pack_item(smallv, smallv, smallv, one, one, 0, one));
    pending_items.push_back(pack_item(big, big, big, 0, 0, 0, smallv));
    pending_items.push_back(pack_item(smallv, big, smallv, smallv, big, smallv, big));
    pending_items.push_back(pack_item(big, big, big, big, big, big, big));
    pending_items.push_back(pack_item(smallv, smallv, smallv, smallv, smallv, smallv,
                                      smallv));
    // Tiny quaternions that need large left shifts, and ones at or above 2^30.
    pending_items.push_back(pack_item(one, -one, 7, 1, 0, 0, 0));
    pending_items.push_back(pack_item(-one, one, 12345, -1, 1, -1, 1));
    pending_items.push_back(pack_item(0, 0, 0, 3, -5, 7, 11));
    pending_items.push_back(pack_item(-1, 1, -1, 32'sh4000_0000, 0, 0, 32'sh4000_0001));
    pending_items.push_back(pack_item(one, one, one, 32'sh4000_0000, 0, 0, 0));
    for (int i = 0; i < 600; i++) begin
      case ($urandom_range(3))
        0: pending_items.push_back({$urandom, $urandom, $urandom, $urandom, $urandom,
                                    $urandom, $urandom});
        1: pending_items.push_back(pack_item($urandom, $urandom, $urandom,
             $signed($urandom) >>> $urandom_range(31), $signed($urandom) >>> $urandom_range(31),
             $signed($urandom) >>> $urandom_range(31), $signed($urandom) >>> $urandom_range(31)));
        2: pending_items.push_back(pack_item($signed($urandom) >>> 8, $signed($urandom) >>> 8,
             $signed($urandom) >>> 8, $urandom, $urandom, $urandom, $urandom));
        default: pending_items.push_back(pack_item($urandom, $urandom, $urandom,
             ($urandom_range(3) == 0) ? 0 : $urandom, ($urandom_range(3) == 0) ? 0 : $urandom,
             ($urandom_range(3) == 0) ? 0 : $urandom, ($urandom_range(7) == 0) ? 0 : $urandom));
      endcase
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_items.size() > 0 || s_axis_tvalid || rotations_due.size() > 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (n_errors == 0 && !m_axis_tvalid) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> filelist.f
sv/qvr_pkg.sv
sv/qvr_norm.sv
sv/qvr_sqrt.sv
sv/qvr_div.sv
sv/qvr_rot.sv
sv/quaternion_vector_rotate.sv
tb/quaternion_vector_rotate_tb.sv
